FILE: src/rrqs_pkg.sv
// Shared types, sizes and helpers for the round-robin quantum scheduler.
package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int WORK_BITS   = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int QUOTA_W     = 8;
    localparam int IN_WORK_W   = 16;
    localparam int REM_W       = 16;
    localparam int STATUS_W    = 3;

    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORK_BITS-1:0] t_work;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [QUOTA_W-1:0]   t_quota;
    typedef logic [REM_W-1:0]     t_rem;

    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_SERVE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_REQUEUED = 3'd2,
        ST_FINISHED = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_OUT
    } t_state;

    typedef struct packed {
        t_id    id;
        t_work  work;
        t_quota quota;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic accept;
        logic serve_done;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_read;
    } t_dp_stat;

    function automatic t_ptr next_ptr(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

FILE: src/rrqs_in_if.sv
// Request channel: task add or serve beats.
interface rrqs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] task_id;
    logic [15:0] total_work;
    logic [7:0] quota;

    modport source (output valid, output kind, output task_id, output total_work,
                    output quota, input ready);
    modport sink   (input valid, input kind, input task_id, input total_work,
                    input quota, output ready);
endinterface

FILE: src/rrqs_out_if.sv
// Result channel: status, served id and remaining work beats.
interface rrqs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  served_id;
    logic [15:0] remaining_work;

    modport source (output valid, output status, output served_id,
                    output remaining_work, input ready);
    modport sink   (input valid, input status, input served_id,
                    input remaining_work, output ready);
endinterface

FILE: src/rrqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/rrqs_datapath.sv
// Datapath: ring pointers, occupancy, task ring memory and result registers.
module rrqs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrqs_pkg::t_dp_cmd  i_cmd,
    output rrqs_pkg::t_dp_stat o_stat,
    input  logic               i_kind,
    input  logic [7:0]         i_task_id,
    input  logic [15:0]        i_total_work,
    input  logic [7:0]         i_quota,
    output logic [2:0]         o_status,
    output logic [7:0]         o_served_id,
    output logic [15:0]        o_remaining_work
);

    rrqs_pkg::t_ptr    r_head, n_head;
    rrqs_pkg::t_ptr    r_tail, n_tail;
    rrqs_pkg::t_cnt    r_occ, n_occ;
    rrqs_pkg::t_status r_status, n_status;
    rrqs_pkg::t_id     r_sid, n_sid;
    rrqs_pkg::t_rem    r_rem, n_rem;

    rrqs_pkg::t_entry  wr_entry;
    rrqs_pkg::t_entry  rd_entry;
    logic [rrqs_pkg::ENTRY_W-1:0] rd_data;
    logic              wr_en;
    logic              rd_en;
    logic              is_full;
    logic              is_empty;
    logic              is_add;
    logic              requeue;
    rrqs_pkg::t_work   left_work;

    assign is_full  = (r_occ == rrqs_pkg::t_cnt'(rrqs_pkg::QUEUE_DEPTH));
    assign is_empty = (r_occ == '0);
    assign is_add   = (rrqs_pkg::t_kind'(i_kind) == rrqs_pkg::KIND_ADD);
    assign o_stat.needs_read = !is_add && !is_empty;

    assign rd_entry  = rrqs_pkg::t_entry'(rd_data);
    assign requeue   = (rd_entry.work > rrqs_pkg::t_work'(rd_entry.quota));
    assign left_work = rd_entry.work - rrqs_pkg::t_work'(rd_entry.quota);

    assign rd_en = i_cmd.accept && o_stat.needs_read;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_status = r_status;
        n_sid    = r_sid;
        n_rem    = r_rem;
        wr_en    = 1'b0;
        wr_entry.id    = rrqs_pkg::t_id'(i_task_id);
        wr_entry.work  = rrqs_pkg::t_work'(i_total_work);
        wr_entry.quota = rrqs_pkg::t_quota'(i_quota);
        priority if (i_cmd.accept) begin
            n_sid = '0;
            n_rem = '0;
            if (is_add) begin
                if (is_full) begin
                    n_status = rrqs_pkg::ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    n_tail   = rrqs_pkg::next_ptr(r_tail);
                    n_occ    = r_occ + rrqs_pkg::t_cnt'(1);
                    n_status = rrqs_pkg::ST_ADDED;
                end
            end else if (is_empty) begin
                n_status = rrqs_pkg::ST_EMPTY;
            end else begin
                n_head = rrqs_pkg::next_ptr(r_head);
            end
        end else if (i_cmd.serve_done) begin
            n_sid = rd_entry.id;
            if (requeue) begin
                wr_en          = 1'b1;
                wr_entry.id    = rd_entry.id;
                wr_entry.work  = left_work;
                wr_entry.quota = rd_entry.quota;
                n_tail         = rrqs_pkg::next_ptr(r_tail);
                n_status       = rrqs_pkg::ST_REQUEUED;
                n_rem          = rrqs_pkg::t_rem'(left_work);
            end else begin
                n_occ    = r_occ - rrqs_pkg::t_cnt'(1);
                n_status = rrqs_pkg::ST_FINISHED;
                n_rem    = '0;
            end
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_sid    <= n_sid;
        r_rem    <= n_rem;
    end

    rrqs_ram #(
        .WIDTH (rrqs_pkg::ENTRY_W),
        .DEPTH (rrqs_pkg::QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    assign o_status         = r_status;
    assign o_served_id      = r_sid;
    assign o_remaining_work = r_rem;

endmodule

FILE: src/rrqs_ctrl.sv
// Controller: sequences accept, ring read, update and result beat.
module rrqs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  rrqs_pkg::t_dp_stat i_stat,
    output rrqs_pkg::t_dp_cmd  o_cmd
);

    rrqs_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrqs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.needs_read ? rrqs_pkg::S_CALC : rrqs_pkg::S_OUT;
                end
            end
            rrqs_pkg::S_CALC: begin
                n_state = rrqs_pkg::S_OUT;
            end
            rrqs_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = rrqs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrqs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.serve_done = 1'b0;
        unique case (r_state)
            rrqs_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            rrqs_pkg::S_CALC: begin
                o_cmd.serve_done = 1'b1;
            end
            rrqs_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrqs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/round_robin_quantum_scheduler.sv
// Top level of the round-robin quantum scheduler.
// An add, a rejected add or a serve on an empty ring shows its result in the cycle after the
// request beat; a serve of a queued task first does a registered ring read, then the update.
// The controller holds one request until its result beat leaves and takes no new one before.
// Reset: synchronous active-low i_rst_n empties the ring (head, tail, occupancy cleared).
module round_robin_quantum_scheduler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrqs_in_if.sink      i_in,
    rrqs_out_if.source   o_out
);

    rrqs_pkg::t_dp_cmd  cmd;
    rrqs_pkg::t_dp_stat stat;

    rrqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rrqs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_in.kind),
        .i_task_id        (i_in.task_id),
        .i_total_work     (i_in.total_work),
        .i_quota          (i_in.quota),
        .o_status         (o_out.status),
        .o_served_id      (o_out.served_id),
        .o_remaining_work (o_out.remaining_work)
    );

endmodule
